@@ sv/bpro_pkg.sv @@
package bpro_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int PIXEL_W     = 8;
   localparam int INDEX_W     = 16;
   localparam int SHIFT_W     = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   localparam int MAP_DEPTH   = 1 << INDEX_W;
   localparam int FN_DEPTH    = 1 << PIXEL_W;

   localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'd255;

   typedef enum logic [2:0] {
      BLEND_COPY        = 3'd0,
      BLEND_TRANSPARENT = 3'd1,
      BLEND_ADD_WRAP    = 3'd2,
      BLEND_ADD_SAT     = 3'd3,
      BLEND_SUB_WRAP    = 3'd4,
      BLEND_SUB_CLAMP   = 3'd5,
      BLEND_COLOUR_MAP  = 3'd6,
      BLEND_COLOUR_FN   = 3'd7
   } blend_type;

   typedef enum logic [1:0] {
      ITEM_PIXEL    = 2'd0,
      ITEM_LOAD_FN  = 2'd1,
      ITEM_LOAD_MAP = 2'd2,
      ITEM_UNUSED   = 2'd3
   } item_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLEND_MODE  = 2'd0,
      CSR_SHADE_SHIFT = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_ALU      = 3'd0,
      OP_MAP      = 3'd1,
      OP_FN       = 3'd2,
      OP_LOAD_FN  = 3'd3,
      OP_LOAD_MAP = 3'd4
   } op_kind_type;

   typedef struct packed {
      op_kind_type          kind;
      logic [INDEX_W-1:0]   addr;
      logic [PIXEL_W-1:0]   data;
      logic                 we;
   } op_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               we;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ sv/bpro_front.sv @@
module bpro_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic [1:0]                     req_mode,
   input  logic [bpro_pkg::PIXEL_W-1:0]   req_src_pixel,
   input  logic [bpro_pkg::PIXEL_W-1:0]   req_dst_pixel,
   input  logic [bpro_pkg::INDEX_W-1:0]   req_table_index,
   input  logic [bpro_pkg::PIXEL_W-1:0]   req_table_value,
   input  logic                           csr_valid,
   input  logic [bpro_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bpro_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  bpro_pkg::queue_status_type     q_status,
   output logic                           op_push,
   output bpro_pkg::op_type               op_out
);
   import bpro_pkg::*;

   blend_type            blend_mode_ff, blend_mode_in;
   logic [SHIFT_W-1:0]   shade_shift_ff, shade_shift_in;

   logic [PIXEL_W:0]     sum9;
   logic [PIXEL_W:0]     diff9;
   logic signed [PIXEL_W+1:0] shade10;
   logic [PIXEL_W-1:0]   shade;
   logic                 keep;

   // CSR writes must come only while idle, which the user ensures; this block takes them whenever offered.
   always_comb begin
      blend_mode_in  = blend_mode_ff;
      shade_shift_in = shade_shift_ff;
      if (csr_valid) begin
         if (csr_index == CSR_BLEND_MODE) begin
            blend_mode_in = blend_type'(csr_wdata[2:0]);
         end
         if (csr_index == CSR_SHADE_SHIFT) begin
            shade_shift_in = csr_wdata[SHIFT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff  <= BLEND_COPY;
         shade_shift_ff <= '0;
      end else begin
         blend_mode_ff  <= blend_mode_in;
         shade_shift_ff <= shade_shift_in;
      end
   end

   always_comb begin
      sum9    = {1'b0, req_dst_pixel} + {1'b0, req_src_pixel};
      diff9   = {1'b0, req_dst_pixel} - {1'b0, req_src_pixel};
      shade10 = $signed({2'b00, req_src_pixel})
              + $signed({shade_shift_ff[SHIFT_W-1], shade_shift_ff});
      if (shade10 < 0) begin
         shade = '0;
      end else if (shade10 > $signed({2'b00, PIXEL_MAX})) begin
         shade = PIXEL_MAX;
      end else begin
         shade = shade10[PIXEL_W-1:0];
      end
   end

   always_comb begin
      op_out.kind = OP_ALU;
      op_out.addr = req_table_index;
      op_out.data = req_table_value;
      op_out.we   = 1'b1;
      keep        = 1'b1;
      unique case (item_type'(req_mode))
         ITEM_PIXEL: begin
            unique case (blend_mode_ff)
               BLEND_COPY: begin
                  op_out.data = req_src_pixel;
               end
               BLEND_TRANSPARENT: begin
                  op_out.data = (req_src_pixel != '0) ? req_src_pixel : req_dst_pixel;
                  op_out.we   = (req_src_pixel != '0);
               end
               BLEND_ADD_WRAP: begin
                  op_out.data = sum9[PIXEL_W-1:0];
               end
               BLEND_ADD_SAT: begin
                  op_out.data = sum9[PIXEL_W] ? PIXEL_MAX : sum9[PIXEL_W-1:0];
               end
               BLEND_SUB_WRAP: begin
                  op_out.data = diff9[PIXEL_W-1:0];
               end
               BLEND_SUB_CLAMP: begin
                  op_out.data = diff9[PIXEL_W] ? '0 : diff9[PIXEL_W-1:0];
               end
               BLEND_COLOUR_MAP: begin
                  op_out.kind = OP_MAP;
                  op_out.addr = {req_dst_pixel, shade};
               end
               BLEND_COLOUR_FN: begin
                  op_out.kind = OP_FN;
                  op_out.addr = {{(INDEX_W-PIXEL_W){1'b0}}, req_src_pixel};
               end
            endcase
         end
         ITEM_LOAD_FN: begin
            op_out.kind = OP_LOAD_FN;
         end
         ITEM_LOAD_MAP: begin
            op_out.kind = OP_LOAD_MAP;
         end
         ITEM_UNUSED: begin
            keep = 1'b0;
         end
      endcase
   end

   // Drop unused item codes at the door: accepted, never queued.
   assign op_push = req_push && !q_status.full && keep;

endmodule

@@ sv/bpro_op_queue.sv @@
module bpro_op_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  bpro_pkg::op_type           push_op,
   input  logic                       pop,
   output bpro_pkg::op_type           head_op,
   output bpro_pkg::queue_status_type status
);
   import bpro_pkg::*;

   op_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_op      = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop  ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_op;
      end
   end

endmodule

@@ sv/bpro_back.sv @@
module bpro_back (
   input  logic                          clock,
   input  logic                          reset,
   input  bpro_pkg::op_type              q_op,
   input  bpro_pkg::queue_status_type    q_status,
   output logic                          q_pop,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output logic [bpro_pkg::PIXEL_W-1:0]  rsp_result_pixel,
   output logic                          rsp_write_enable
);
   import bpro_pkg::*;

   logic [PIXEL_W-1:0]  map_mem [MAP_DEPTH];
   logic [PIXEL_W-1:0]  fn_mem  [FN_DEPTH];

   logic [PIXEL_W-1:0]  map_rd_ff;
   logic [PIXEL_W-1:0]  fn_rd_ff;
   op_type              op_ff;
   logic                s1_valid_ff, s1_valid_in;
   logic                is_pixel;
   rsp_type             s1_rsp;

   rsp_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   // Pull the next op only if the result queue has room for it and the
   // one in flight.
   assign q_pop = !q_status.empty
                && ((count_ff + QCNT_W'(s1_valid_ff)) < QCNT_W'(QUEUE_DEPTH));

   assign is_pixel = (q_op.kind == OP_ALU) || (q_op.kind == OP_MAP)
                  || (q_op.kind == OP_FN);
   assign s1_valid_in = q_pop && is_pixel;

   always_ff @(posedge clock) begin
      if (q_pop && (q_op.kind == OP_LOAD_MAP)) begin
         map_mem[q_op.addr] <= q_op.data;
      end
      if (q_pop && (q_op.kind == OP_LOAD_FN)) begin
         fn_mem[q_op.addr[PIXEL_W-1:0]] <= q_op.data;
      end
      map_rd_ff <= map_mem[q_op.addr];
      fn_rd_ff  <= fn_mem[q_op.addr[PIXEL_W-1:0]];
      op_ff     <= q_op;
   end

   always_comb begin
      s1_rsp.we = op_ff.we;
      unique case (op_ff.kind)
         OP_MAP:  s1_rsp.pixel = map_rd_ff;
         OP_FN:   s1_rsp.pixel = fn_rd_ff;
         default: s1_rsp.pixel = op_ff.data;
      endcase
   end

   assign rsp_empty        = (count_ff == '0);
   assign do_pop           = rsp_pop && !rsp_empty;
   assign rsp_result_pixel = entry_ff[rptr_ff].pixel;
   assign rsp_write_enable = entry_ff[rptr_ff].we;

   always_comb begin
      wptr_in  = s1_valid_ff ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop      ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + QCNT_W'(s1_valid_ff) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wptr_ff     <= '0;
         rptr_ff     <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         wptr_ff     <= wptr_in;
         rptr_ff     <= rptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         entry_ff[wptr_ff] <= s1_rsp;
      end
   end

endmodule

@@ sv/blit_pixel_raster_op.sv @@
// Per-pixel raster operation of an 8-bit blitter.
// Request channel: drive req_* and push; a request is taken on a clock edge
// with push high and req_full low. Pixel requests (mode 0) give one result;
// load requests (mode 1 color function entry, mode 2 color map entry)
// write a table and give none; mode 3 is taken and dropped.
// Result channel: while rsp_empty is low the oldest result sits on
// rsp_result_pixel / rsp_write_enable; raise rsp_pop to take it.
// CSR channel: csr_ready is always high; index 0 blend mode, index 1 shade
// shift (9-bit two's complement). Write CSRs only while the block is idle.
// A pixel request passes through the op queue, the table read registers and
// the result queue. Throughput: one request per cycle while req_full is low;
// the back end reads its single-port tables for one item at a time.
// Reset clears both queues, the blend mode and the shade shift. Table
// contents are not cleared; load entries before reading them.
// When the receiver stalls, results collect in a 4-entry result queue, then
// the 4-entry op queue fills and req_full rises; nothing is lost.
module blit_pixel_raster_op (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             req_full,
   input  logic [1:0]                       req_mode,
   input  logic [bpro_pkg::PIXEL_W-1:0]     req_src_pixel,
   input  logic [bpro_pkg::PIXEL_W-1:0]     req_dst_pixel,
   input  logic [bpro_pkg::INDEX_W-1:0]     req_table_index,
   input  logic [bpro_pkg::PIXEL_W-1:0]     req_table_value,
   output logic                             rsp_empty,
   input  logic                             pop,
   output logic [bpro_pkg::PIXEL_W-1:0]     rsp_result_pixel,
   output logic                             rsp_write_enable,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bpro_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bpro_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bpro_pkg::*;

   queue_status_type q_status;
   op_type           front_op;
   op_type           head_op;
   logic             op_push;
   logic             op_pop;

   // Registers take every write at once.
   assign csr_ready = 1'b1;
   assign req_full  = q_status.full;

   // Front: hold CSRs, classify the request, precompute ALU results and
   // table addresses.
   bpro_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (push),
      .req_mode        (req_mode),
      .req_src_pixel   (req_src_pixel),
      .req_dst_pixel   (req_dst_pixel),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .q_status        (q_status),
      .op_push         (op_push),
      .op_out          (front_op)
   );

   // Decouple front and back so each side stalls on its own.
   bpro_op_queue u_op_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (op_push),
      .push_op (front_op),
      .pop     (op_pop),
      .head_op (head_op),
      .status  (q_status)
   );

   // Back: write or read the tables in order, queue results.
   bpro_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_op             (head_op),
      .q_status         (q_status),
      .q_pop            (op_pop),
      .rsp_pop          (pop),
      .rsp_empty        (rsp_empty),
      .rsp_result_pixel (rsp_result_pixel),
      .rsp_write_enable (rsp_write_enable)
   );

endmodule
